>>> hw/rtl/kcs_pkg.sv
package kcs_pkg;

  localparam int MAX_KEYS    = 256;
  localparam int ANGLE_UNITS = 4096;
  localparam int FRAC_BITS   = 12;

  localparam int ANGLE_BITS  = $clog2(ANGLE_UNITS);
  localparam int ANGLE_HALF  = ANGLE_UNITS / 2;

  localparam int OP_W       = 2;
  localparam int STEP_W     = 16;
  localparam int VALUE_W    = 16;
  localparam int TIME_W     = 24;
  localparam int KEY_W      = 8;
  localparam int FACTOR_W   = 13;
  localparam int BLEND_W    = 17;
  localparam int COUNT_W    = 9;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Clip time plus one step, before wrap or clamp.
  localparam int SUM_W      = TIME_W + 1;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int PROD_W     = BLEND_W + FACTOR_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_RESTART = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_BLEND   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_ENABLED = 2'd0,
    CFG_KEY_COUNT    = 2'd1,
    CFG_KEY_PERIOD   = 2'd2,
    CFG_LOOPING      = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_WRAP,
    DIV_INDEX,
    DIV_KEY,
    DIV_FRAC
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_UPDATE,
    S_WRAP_WAIT,
    S_INDEX,
    S_INDEX_WAIT,
    S_KEY,
    S_KEY_WAIT,
    S_FRAC,
    S_FRAC_WAIT,
    S_MUL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     update;
    logic     div_start;
    logic     div_take;
    div_sel_t div_sel;
    logic     no_keys;
    logic     mul;
    logic     emit;
  } kcs_cmd_t;

  typedef struct packed {
    logic advance;
    logic keys_ok;
    logic looping;
    logic span_zero;
    logic div_busy;
    logic out_free;
  } kcs_status_t;

endpackage

>>> hw/rtl/kcs_item_if.sv
interface kcs_item_if;
  logic                                valid;
  logic                                ready;
  logic [kcs_pkg::OP_W-1:0]            operation;
  logic [kcs_pkg::STEP_W-1:0]          step_ms;
  logic signed [kcs_pkg::VALUE_W-1:0]  from_value;
  logic signed [kcs_pkg::VALUE_W-1:0]  to_value;
  logic                                is_angle;
  logic signed [kcs_pkg::VALUE_W-1:0]  base_value;

  modport source (
    output valid, operation, step_ms, from_value, to_value, is_angle, base_value,
    input  ready
  );

  modport sink (
    input  valid, operation, step_ms, from_value, to_value, is_angle, base_value,
    output ready
  );
endinterface

>>> hw/rtl/kcs_result_if.sv
interface kcs_result_if;
  logic                                valid;
  logic                                ready;
  logic [kcs_pkg::TIME_W-1:0]          clip_time_ms;
  logic                                finished;
  logic [kcs_pkg::KEY_W-1:0]           from_key;
  logic [kcs_pkg::KEY_W-1:0]           to_key;
  logic [kcs_pkg::FACTOR_W-1:0]        blend_factor;
  logic signed [kcs_pkg::BLEND_W-1:0]  blended_value;

  modport source (
    output valid, clip_time_ms, finished, from_key, to_key, blend_factor, blended_value,
    input  ready
  );

  modport sink (
    input  valid, clip_time_ms, finished, from_key, to_key, blend_factor, blended_value,
    output ready
  );
endinterface

>>> hw/rtl/kcs_div.sv
module kcs_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [kcs_pkg::DIV_CNT_W-1:0]   iters,
  input  logic [kcs_pkg::SUM_W-1:0]       num,
  input  logic [kcs_pkg::TIME_W-1:0]      init_rem,
  input  logic [kcs_pkg::TIME_W-1:0]      den,
  output logic                            busy,
  output logic [kcs_pkg::SUM_W-1:0]       quot,
  output logic [kcs_pkg::TIME_W-1:0]      rem
);
  import kcs_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W:0]      shifted;
  logic [TIME_W+1:0]    trial;
  logic                 fits;
  logic [TIME_W-1:0]    rem_next;

  // Restoring division, one quotient bit per cycle. The numerator sits
  // left-aligned in quot and is shifted out as the quotient shifts in.
  assign shifted  = {rem, quot[SUM_W-1]};
  assign trial    = {1'b0, shifted} - {2'b00, den};
  assign fits     = !trial[TIME_W+1];
  assign rem_next = fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= init_rem;
    end else if (busy) begin
      quot <= {quot[SUM_W-2:0], fits};
      rem  <= rem_next;
    end
  end

endmodule

>>> hw/rtl/kcs_datapath.sv
module kcs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [kcs_pkg::OP_W-1:0]           operation,
  input  logic [kcs_pkg::STEP_W-1:0]         step_ms,
  input  logic signed [kcs_pkg::VALUE_W-1:0] from_value,
  input  logic signed [kcs_pkg::VALUE_W-1:0] to_value,
  input  logic                               is_angle,
  input  logic signed [kcs_pkg::VALUE_W-1:0] base_value,
  input  kcs_pkg::kcs_cmd_t                  cmd,
  output kcs_pkg::kcs_status_t               status,
  kcs_result_if.source                       results
);
  import kcs_pkg::*;

  // Configuration registers
  logic                 clip_enabled;
  logic [COUNT_W-1:0]   key_count;
  logic [PERIOD_W-1:0]  key_period;
  logic                 looping;

  // Latched input item
  logic [OP_W-1:0]      op_r;
  logic [STEP_W-1:0]    step_r;
  logic [VALUE_W-1:0]   from_r;
  logic [VALUE_W-1:0]   to_r;
  logic                 angle_r;
  logic [VALUE_W-1:0]   base_r;

  // Clip state and working registers
  logic [TIME_W-1:0]    elapsed;
  logic                 done;
  logic [TIME_W-1:0]    span;
  logic [SUM_W-1:0]     tm;
  logic [TIME_W-1:0]    index;
  logic [PERIOD_W-1:0]  frac_rem;
  logic [KEY_W-1:0]     key_a;
  logic [FACTOR_W-1:0]  factor;
  logic signed [PROD_W-1:0] prod;

  // Result register
  logic                 out_valid;
  logic [TIME_W-1:0]    out_time;
  logic                 out_finished;
  logic [KEY_W-1:0]     out_from_key;
  logic [KEY_W-1:0]     out_to_key;
  logic [FACTOR_W-1:0]  out_factor;
  logic [BLEND_W-1:0]   out_blended;

  logic [COUNT_W-1:0]   n;
  logic [COUNT_W-1:0]   last;
  logic                 keys_ok;
  logic [COUNT_W-1:0]   span_keys;
  logic [COUNT_W+PERIOD_W-1:0] span_full;

  logic                 div_start;
  logic [DIV_CNT_W-1:0] div_iters;
  logic [SUM_W-1:0]     div_num;
  logic [TIME_W-1:0]    div_init;
  logic [TIME_W-1:0]    div_den;
  logic                 div_busy;
  logic [SUM_W-1:0]     div_quot;
  logic [TIME_W-1:0]    div_rem;

  logic [COUNT_W-1:0]   key_a_inc;
  logic [KEY_W-1:0]     key_b;

  logic [BLEND_W-1:0]   diff;
  logic [BLEND_W-1:0]   wrap_sum;
  logic [ANGLE_BITS-1:0] ang_m;
  logic [BLEND_W-1:0]   ang_d;
  logic [BLEND_W-1:0]   mul_a;
  logic signed [PROD_W-1:0] mul_a_x;
  logic signed [PROD_W-1:0] mul_t_x;
  logic signed [PROD_W-1:0] prod_shift;
  logic [VALUE_W-1:0]   lerp;
  logic [BLEND_W-1:0]   lerp_x;
  logic [BLEND_W-1:0]   base_x;
  logic [BLEND_W-1:0]   blended;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enabled <= 1'b0;
      key_count    <= '0;
      key_period   <= PERIOD_W'(1);
      looping      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLIP_ENABLED: clip_enabled <= cfg_wdata[0];
        CFG_KEY_COUNT:    key_count    <= cfg_wdata[COUNT_W-1:0];
        CFG_KEY_PERIOD:   key_period   <= cfg_wdata[PERIOD_W-1:0];
        CFG_LOOPING:      looping      <= cfg_wdata[0];
      endcase
    end
  end

  assign n         = (key_count > COUNT_W'(MAX_KEYS)) ? COUNT_W'(MAX_KEYS) : key_count;
  assign last      = n - 1'b1;
  assign keys_ok   = clip_enabled && (n > COUNT_W'(1)) && (key_period != '0);
  assign span_keys = looping ? n : ((n != '0) ? last : '0);
  assign span_full = {{PERIOD_W{1'b0}}, span_keys} * {{COUNT_W{1'b0}}, key_period};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= operation;
      step_r  <= step_ms;
      from_r  <= from_value;
      to_r    <= to_value;
      angle_r <= is_angle;
      base_r  <= base_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      done    <= 1'b0;
    end else if (cmd.prep && (op_r == OP_RESTART)) begin
      elapsed <= '0;
      done    <= 1'b0;
    end else if (cmd.update) begin
      if (span == '0) begin
        elapsed <= '0;
        done    <= !looping;
      end else if (!looping) begin
        if (tm >= {1'b0, span}) begin
          elapsed <= span;
          done    <= 1'b1;
        end else begin
          elapsed <= tm[TIME_W-1:0];
        end
      end
    end else if (cmd.div_take && (cmd.div_sel == DIV_WRAP)) begin
      elapsed <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      span <= span_full[TIME_W-1:0];
      tm   <= {1'b0, elapsed} + {{(SUM_W-STEP_W){1'b0}}, step_r};
    end
  end

  // Divider operands for the four divisions an item may need.
  always_comb begin
    unique case (cmd.div_sel)
      DIV_WRAP: begin
        div_num   = tm;
        div_init  = '0;
        div_den   = span;
        div_iters = DIV_CNT_W'(SUM_W);
      end
      DIV_INDEX: begin
        div_num   = {elapsed, 1'b0};
        div_init  = '0;
        div_den   = {{(TIME_W-PERIOD_W){1'b0}}, key_period};
        div_iters = DIV_CNT_W'(TIME_W);
      end
      DIV_KEY: begin
        div_num   = {index, 1'b0};
        div_init  = '0;
        div_den   = {{(TIME_W-COUNT_W){1'b0}}, n};
        div_iters = DIV_CNT_W'(TIME_W);
      end
      DIV_FRAC: begin
        div_num   = '0;
        div_init  = {{(TIME_W-PERIOD_W){1'b0}}, frac_rem};
        div_den   = {{(TIME_W-PERIOD_W){1'b0}}, key_period};
        div_iters = DIV_CNT_W'(FRAC_BITS);
      end
    endcase
  end

  assign div_start = cmd.div_start;

  kcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .iters    (div_iters),
    .num      (div_num),
    .init_rem (div_init),
    .den      (div_den),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.no_keys) begin
      key_a  <= '0;
      factor <= '0;
    end else if (cmd.div_take) begin
      unique case (cmd.div_sel)
        DIV_WRAP: begin
        end
        DIV_INDEX: begin
          index    <= div_quot[TIME_W-1:0];
          frac_rem <= div_rem[PERIOD_W-1:0];
          if (!looping) begin
            key_a <= (div_quot[TIME_W-1:0] > TIME_W'(last)) ? last[KEY_W-1:0]
                                                          : div_quot[KEY_W-1:0];
          end
        end
        DIV_KEY:  key_a  <= div_rem[KEY_W-1:0];
        DIV_FRAC: factor <= FACTOR_W'(div_quot[FRAC_BITS-1:0]);
      endcase
    end
  end

  // Looping clips wrap from the last key back to key 0.
  assign key_a_inc = {1'b0, key_a} + 1'b1;
  always_comb begin
    if (!keys_ok) begin
      key_b = '0;
    end else if (looping) begin
      key_b = (key_a_inc == n) ? '0 : key_a_inc[KEY_W-1:0];
    end else begin
      key_b = ({1'b0, key_a} < last) ? key_a_inc[KEY_W-1:0] : last[KEY_W-1:0];
    end
  end

  // Angles take the shortest way around the circle.
  assign diff     = {to_r[VALUE_W-1], to_r} - {from_r[VALUE_W-1], from_r};
  assign wrap_sum = diff + BLEND_W'(ANGLE_HALF);
  assign ang_m    = wrap_sum[ANGLE_BITS-1:0];
  assign ang_d    = {{(BLEND_W-ANGLE_BITS){1'b0}}, ang_m} - BLEND_W'(ANGLE_HALF);
  assign mul_a    = angle_r ? ang_d : diff;
  assign mul_a_x  = signed'({{(PROD_W-BLEND_W){mul_a[BLEND_W-1]}}, mul_a});
  assign mul_t_x  = signed'({{(PROD_W-FACTOR_W){1'b0}}, factor});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= mul_a_x * mul_t_x;
    end
  end

  assign prod_shift = prod >>> FRAC_BITS;
  assign lerp       = from_r + prod_shift[VALUE_W-1:0];
  assign lerp_x     = {lerp[VALUE_W-1], lerp};
  assign base_x     = {base_r[VALUE_W-1], base_r};

  always_comb begin
    if (op_r != OP_BLEND) begin
      blended = '0;
    end else if (!clip_enabled) begin
      blended = angle_r ? '0 : base_x;
    end else if (angle_r) begin
      blended = lerp_x;
    end else begin
      blended = base_x + lerp_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_time     <= elapsed;
      out_finished <= done;
      out_from_key <= key_a;
      out_to_key   <= key_b;
      out_factor   <= factor;
      out_blended  <= blended;
    end
  end

  assign results.valid         = out_valid;
  assign results.clip_time_ms  = out_time;
  assign results.finished      = out_finished;
  assign results.from_key      = out_from_key;
  assign results.to_key        = out_to_key;
  assign results.blend_factor  = out_factor;
  assign results.blended_value = signed'(out_blended);

  assign status.advance   = (op_r == OP_ADVANCE) && clip_enabled;
  assign status.keys_ok   = keys_ok;
  assign status.looping   = looping;
  assign status.span_zero = (span == '0);
  assign status.div_busy  = div_busy;
  assign status.out_free  = !out_valid || results.ready;

endmodule

>>> hw/rtl/kcs_ctrl.sv
module kcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  kcs_pkg::kcs_status_t status,
  output kcs_pkg::kcs_cmd_t    cmd
);
  import kcs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_WRAP;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.advance ? S_UPDATE : S_INDEX;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (!status.span_zero && status.looping) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_WRAP;
          state_next    = S_WRAP_WAIT;
        end else begin
          state_next = S_INDEX;
        end
      end
      S_WRAP_WAIT: begin
        cmd.div_sel = DIV_WRAP;
        if (!status.div_busy) begin
          cmd.div_take = 1'b1;
          state_next   = S_INDEX;
        end
      end
      S_INDEX: begin
        cmd.div_sel = DIV_INDEX;
        if (status.keys_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_INDEX_WAIT;
        end else begin
          cmd.no_keys = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_INDEX_WAIT: begin
        cmd.div_sel = DIV_INDEX;
        if (!status.div_busy) begin
          cmd.div_take = 1'b1;
          state_next   = status.looping ? S_KEY : S_FRAC;
        end
      end
      S_KEY: begin
        cmd.div_sel   = DIV_KEY;
        cmd.div_start = 1'b1;
        state_next    = S_KEY_WAIT;
      end
      S_KEY_WAIT: begin
        cmd.div_sel = DIV_KEY;
        if (!status.div_busy) begin
          cmd.div_take = 1'b1;
          state_next   = S_FRAC;
        end
      end
      S_FRAC: begin
        cmd.div_sel   = DIV_FRAC;
        cmd.div_start = 1'b1;
        state_next    = S_FRAC_WAIT;
      end
      S_FRAC_WAIT: begin
        cmd.div_sel = DIV_FRAC;
        if (!status.div_busy) begin
          cmd.div_take = 1'b1;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/keyframe_clip_sampler.sv
// Channel    Dir  Handshake      Payload
// items      in   valid/ready    operation, step_ms, from_value, to_value, is_angle,
//                                base_value
// results    out  valid/ready    clip_time_ms, finished, from_key, to_key,
//                                blend_factor, blended_value
// cfg        in   cfg_we         cfg_index, cfg_wdata (no read-back)
//
// One item is in flight at a time; its result waits on whichever divisions it needs
// from the shared restoring divider at one quotient bit per cycle: a looping wrap
// (25 bits), the key index (24), the key modulo for looping clips (24) and the blend
// fraction (12). The next item can be taken once the result is presented.
// Synchronous reset clears clip time, finished flag and config but sets period to 1.
// A waiting result does not block input; the next result stalls until it leaves.
module keyframe_clip_sampler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  kcs_item_if.sink                       items,
  kcs_result_if.source                   results
);
  import kcs_pkg::*;

  kcs_cmd_t    cmd;
  kcs_status_t status;
  logic        in_ready;

  assign items.ready = in_ready;

  kcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kcs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .operation  (items.operation),
    .step_ms    (items.step_ms),
    .from_value (items.from_value),
    .to_value   (items.to_value),
    .is_angle   (items.is_angle),
    .base_value (items.base_value),
    .cmd        (cmd),
    .status     (status),
    .results    (results)
  );

  // The block is busy for the rest of an accepted transaction.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready
  ) else $error("input accepted twice in a row");

  a_no_instant_result: assert property (
    @(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !$rose(results.valid)
  ) else $error("result appeared right after acceptance");

  a_factor_range: assert property (
    @(posedge clk) disable iff (rst)
    results.valid |-> (results.blend_factor <= FACTOR_W'(1 << FRAC_BITS))
  ) else $error("blend factor above one");

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kcs_pkg::*;

  // The fourth operation code has no meaning; the block must still answer it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RUN_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_PHASES = 11;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [STEP_W-1:0]         step_ms;
    logic signed [VALUE_W-1:0] from_value;
    logic signed [VALUE_W-1:0] to_value;
    logic                      is_angle;
    logic signed [VALUE_W-1:0] base_value;
  } clip_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]         clip_time_ms;
    logic                      finished;
    logic [KEY_W-1:0]          from_key;
    logic [KEY_W-1:0]          to_key;
    logic [FACTOR_W-1:0]       blend_factor;
    logic signed [BLEND_W-1:0] blended_value;
  } clip_sample_t;

  class clip_sample_tracker;
    logic                clip_on;
    logic [COUNT_W-1:0]  key_count;
    logic [PERIOD_W-1:0] period;
    logic                looping;
    logic [TIME_W-1:0]   elapsed;
    logic                done;
    clip_sample_t        pending_samples[$];
    int                  checked;
    int                  failures;
    int                  wraps;
    int                  clamps;

    function new();
      clip_on   = 1'b0;
      key_count = '0;
      period    = PERIOD_W'(1);
      looping   = 1'b0;
      elapsed   = '0;
      done      = 1'b0;
      checked   = 0;
      failures  = 0;
      wraps     = 0;
      clamps    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CLIP_ENABLED: clip_on   = data[0];
        CFG_KEY_COUNT:    key_count = data[COUNT_W-1:0];
        CFG_KEY_PERIOD:   period    = data[PERIOD_W-1:0];
        CFG_LOOPING:      looping   = data[0];
      endcase
    endfunction

    // Works out the clip state after one item and queues the sample it yields.
    function void take_item(clip_item_t it);
      longint unsigned n, span, tm, idx, rem, frac, ka, kb, last;
      longint a, b, base, t, m, d, mix, blended;
      logic signed [VALUE_W-1:0] v16;
      clip_sample_t s;
      n = (key_count > COUNT_W'(MAX_KEYS)) ? 64'(MAX_KEYS) : 64'(key_count);
      a = it.from_value;
      b = it.to_value;
      base = it.base_value;
      ka = 0;
      kb = 0;
      t = 0;
      blended = 0;
      if (it.operation == OP_RESTART) begin
        elapsed = '0;
        done = 1'b0;
      end else if (it.operation == OP_ADVANCE && clip_on) begin
        if (looping) begin
          span = n * 64'(period);
        end else begin
          span = (n > 0) ? (n - 1) * 64'(period) : 64'd0;
        end
        tm = 64'(elapsed) + 64'(it.step_ms);
        if (span == 0) begin
          tm = 0;
          done = !looping;
        end else if (looping) begin
          if (tm >= span) wraps++;
          tm = tm % span;
        end else if (tm >= span) begin
          tm = span;
          done = 1'b1;
          clamps++;
        end
        elapsed = tm[TIME_W-1:0];
      end
      if (clip_on && n > 1 && period != 0) begin
        idx = 64'(elapsed) / 64'(period);
        rem = 64'(elapsed) - idx * 64'(period);
        if (looping) begin
          ka = idx % n;
          kb = (ka + 1) % n;
        end else begin
          last = n - 1;
          ka = (idx > last) ? last : idx;
          kb = (ka < last) ? ka + 1 : last;
        end
        frac = (rem << FRAC_BITS) / 64'(period);
        if (frac > (64'd1 << FRAC_BITS)) frac = 64'd1 << FRAC_BITS;
        t = longint'(frac);
      end
      if (it.operation == OP_BLEND) begin
        if (!clip_on) begin
          blended = it.is_angle ? 64'sd0 : base;
        end else if (it.is_angle) begin
          // Shortest way around the circle: the difference folds into half a turn.
          m = (b - a + ANGLE_HALF) & longint'(ANGLE_UNITS - 1);
          d = m - ANGLE_HALF;
          mix = a + ((d * t) >>> FRAC_BITS);
          v16 = mix[VALUE_W-1:0];
          blended = v16;
        end else begin
          mix = a + (((b - a) * t) >>> FRAC_BITS);
          v16 = mix[VALUE_W-1:0];
          blended = base + v16;
        end
      end
      s.clip_time_ms  = elapsed;
      s.finished      = done;
      s.from_key      = ka[KEY_W-1:0];
      s.to_key        = kb[KEY_W-1:0];
      s.blend_factor  = t[FACTOR_W-1:0];
      s.blended_value = blended[BLEND_W-1:0];
      pending_samples.push_back(s);
    endfunction

    function string show(clip_sample_t s);
      return $sformatf("time=%0d fin=%0d keys=%0d/%0d factor=%0d value=%0d",
                       s.clip_time_ms, s.finished, s.from_key, s.to_key,
                       s.blend_factor, s.blended_value);
    endfunction

    function void match_sample(clip_sample_t got);
      clip_sample_t want;
      checked++;
      if (pending_samples.size() == 0) begin
        failures++;
        if (failures <= 10) $display("tb_top: unexpected result: %s", show(got));
        return;
      end
      want = pending_samples.pop_front();
      if (got.clip_time_ms !== want.clip_time_ms || got.finished !== want.finished ||
          got.from_key !== want.from_key || got.to_key !== want.to_key ||
          got.blend_factor !== want.blend_factor ||
          got.blended_value !== want.blended_value) begin
        failures++;
        if (failures <= 10) begin
          $display("tb_top: mismatch at result %0d", checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kcs_item_if   items_if ();
  kcs_result_if results_if ();

  keyframe_clip_sampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .items     (items_if),
    .results   (results_if)
  );

  always #10 clk = ~clk;

  clip_sample_tracker sb;
  bit steady;
  bit holding;
  int burst_left;
  int items_sent;
  int phases_run;

  task automatic send_item(input clip_item_t it);
    items_if.valid      <= 1'b1;
    items_if.operation  <= it.operation;
    items_if.step_ms    <= it.step_ms;
    items_if.from_value <= it.from_value;
    items_if.to_value   <= it.to_value;
    items_if.is_angle   <= it.is_angle;
    items_if.base_value <= it.base_value;
    holding = 1'b1;
    do @(posedge clk); while (items_if.ready !== 1'b1);
    sb.take_item(it);
    items_sent++;
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        items_if.valid <= 1'b0;
        holding = 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic send(input logic [OP_W-1:0] op, input logic [STEP_W-1:0] step,
                      input logic signed [VALUE_W-1:0] from_v,
                      input logic signed [VALUE_W-1:0] to_v, input logic angle,
                      input logic signed [VALUE_W-1:0] base_v);
    clip_item_t it;
    it.operation  = op;
    it.step_ms    = step;
    it.from_value = from_v;
    it.to_value   = to_v;
    it.is_angle   = angle;
    it.base_value = base_v;
    send_item(it);
  endtask

  // The block is idle once the sender is quiet and every sample has come back.
  task automatic settle();
    if (holding) begin
      items_if.valid <= 1'b0;
      holding = 1'b0;
    end
    while (sb.pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic en, input logic [CFG_DATA_W-1:0] keys,
                           input logic [CFG_DATA_W-1:0] per, input logic lp,
                           input bit garble);
    logic [3:0][CFG_DATA_W-1:0] vals;
    vals[0] = CFG_DATA_W'(en);
    vals[1] = keys;
    vals[2] = per;
    vals[3] = CFG_DATA_W'(lp);
    // Bits above a register's width must be dropped by the block.
    if (garble) begin
      vals[0][CFG_DATA_W-1:1]       = (CFG_DATA_W-1)'($urandom);
      vals[1][CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W-COUNT_W)'($urandom);
      vals[3][CFG_DATA_W-1:1]       = (CFG_DATA_W-1)'($urandom);
    end
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= vals[i];
      sb.write_reg(cfg_idx_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic clip_item_t random_item(bit long_run);
    clip_item_t it;
    int pick;
    int hi;
    pick = $urandom_range(0, 99);
    if (long_run) begin
      if (pick < 83)      it.operation = OP_ADVANCE;
      else if (pick < 98) it.operation = OP_BLEND;
      else                it.operation = OP_UNUSED;
      it.step_ms = ($urandom_range(0, 9) != 0) ? 16'hFFFF : STEP_W'($urandom);
    end else begin
      if (pick < 8)       it.operation = OP_RESTART;
      else if (pick < 48) it.operation = OP_ADVANCE;
      else if (pick < 93) it.operation = OP_BLEND;
      else                it.operation = OP_UNUSED;
      pick = $urandom_range(0, 19);
      hi = 3 * int'(sb.period) + 3;
      if (hi > 65535) hi = 65535;
      if (pick < 7)       it.step_ms = STEP_W'($urandom_range(0, hi));
      else if (pick < 10) it.step_ms = pick[0] ? 16'hFFFF : 16'h0000;
      else                it.step_ms = STEP_W'($urandom);
    end
    it.from_value = pick_value();
    it.to_value   = pick_value();
    it.is_angle   = 1'($urandom_range(0, 1));
    it.base_value = pick_value();
    return it;
  endfunction

  task automatic random_config();
    logic [CFG_DATA_W-1:0] keys, per;
    case ($urandom_range(0, 7))
      0:       keys = 16'd0;
      1:       keys = 16'd1;
      2:       keys = 16'd2;
      3:       keys = CFG_DATA_W'($urandom_range(3, 8));
      4:       keys = CFG_DATA_W'($urandom_range(9, 40));
      5:       keys = 16'd256;
      6:       keys = CFG_DATA_W'($urandom_range(257, 511));
      default: keys = CFG_DATA_W'($urandom_range(0, 511));
    endcase
    case ($urandom_range(0, 5))
      0:       per = 16'd0;
      1:       per = 16'd1;
      2:       per = CFG_DATA_W'($urandom_range(2, 16));
      3:       per = CFG_DATA_W'($urandom_range(17, 1000));
      4:       per = 16'hFFFF;
      default: per = CFG_DATA_W'($urandom_range(1, 65535));
    endcase
    configure($urandom_range(0, 9) != 0, keys, per, 1'($urandom_range(0, 1)),
              $urandom_range(0, 3) == 0);
  endtask

  initial begin : watchdog
    repeat (RUN_LIMIT) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : result_sink
    clip_sample_t got;
    int ready_left;
    int stall_left;
    ready_left = 0;
    stall_left = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
        got.clip_time_ms  = results_if.clip_time_ms;
        got.finished      = results_if.finished;
        got.from_key      = results_if.from_key;
        got.to_key        = results_if.to_key;
        got.blend_factor  = results_if.blend_factor;
        got.blended_value = results_if.blended_value;
        sb.match_sample(got);
      end
      if (ready_left == 0 && stall_left == 0) begin
        ready_left = $urandom_range(1, 12);
        stall_left = $urandom_range(0, 6);
      end
      if (steady || ready_left > 0) begin
        results_if.ready <= 1'b1;
        if (ready_left > 0) ready_left--;
      end else begin
        results_if.ready <= 1'b0;
        stall_left--;
      end
    end
  end

  initial begin : stimulus
    int count;
    bit long_run;
    sb = new();
    steady = 1'b0;
    holding = 1'b0;
    burst_left = 4;
    items_sent = 0;
    phases_run = 0;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_CLIP_ENABLED;
    cfg_wdata           <= '0;
    items_if.valid      <= 1'b0;
    items_if.operation  <= OP_RESTART;
    items_if.step_ms    <= '0;
    items_if.from_value <= '0;
    items_if.to_value   <= '0;
    items_if.is_angle   <= 1'b0;
    items_if.base_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Out of reset there is no clip: time stays frozen and blends are neutral.
    send(OP_ADVANCE, 16'hFFFF, 16'sd5, 16'sd9, 1'b0, 16'sd3);
    send(OP_BLEND, 16'h0000, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF);
    send(OP_BLEND, 16'h0000, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh8000);
    send(OP_UNUSED, 16'hA5A5, 16'sh5A5A, 16'shA5A5, 1'b1, 16'sh1234);
    send(OP_RESTART, 16'hFFFF, 16'shFFFF, 16'shFFFF, 1'b1, 16'shFFFF);

    // A single key gives a zero span and a one-shot clip finishes at once.
    settle();
    configure(1'b1, 16'd1, 16'd100, 1'b0, 1'b0);
    send(OP_ADVANCE, 16'd5, 16'sd0, 16'sd0, 1'b0, 16'sd0);
    send(OP_BLEND, 16'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh7FFF);
    send(OP_RESTART, 16'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0);

    // Too many keys saturate; a zero period still gives a zero span.
    settle();
    configure(1'b1, 16'd300, 16'd0, 1'b1, 1'b0);
    send(OP_ADVANCE, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0);
    send(OP_BLEND, 16'd0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sd0);

    // Two long keys: a one-shot clamps at the last key.
    settle();
    configure(1'b1, 16'd2, 16'hFFFF, 1'b0, 1'b0);
    send(OP_ADVANCE, 16'd40000, 16'sd0, 16'sd0, 1'b0, 16'sd0);
    send(OP_BLEND, 16'd0, 16'sd100, 16'sd4000, 1'b1, 16'sd0);
    send(OP_BLEND, 16'd0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sh8000);
    send(OP_ADVANCE, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0);
    send(OP_BLEND, 16'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd0);
    send(OP_ADVANCE, 16'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0);

    // Short loop: the last key blends back into key zero, and time wraps.
    settle();
    configure(1'b1, 16'd3, 16'd7, 1'b1, 1'b0);
    send(OP_RESTART, 16'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0);
    send(OP_ADVANCE, 16'd20, 16'sd0, 16'sd0, 1'b0, 16'sd0);
    send(OP_BLEND, 16'd0, -16'sd2048, 16'sd2047, 1'b1, 16'sd0);
    send(OP_ADVANCE, 16'hFFFF, 16'sd0, 16'sd0, 1'b0, 16'sd0);
    send(OP_UNUSED, 16'h5A5A, 16'sh0F0F, 16'shF0F0, 1'b0, 16'sh00FF);
    send(OP_BLEND, 16'd0, -16'sd300, 16'sd1200, 1'b0, 16'sd77);

    // Detaching the clip freezes time again.
    settle();
    configure(1'b0, 16'd3, 16'd7, 1'b1, 1'b0);
    send(OP_ADVANCE, 16'd3, 16'sd0, 16'sd0, 1'b0, 16'sd0);
    send(OP_BLEND, 16'd0, 16'sd1000, 16'sd2000, 1'b1, 16'sd555);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      long_run = 1'b0;
      count = 90;
      case (p)
        0: begin
          // Largest looping span: long steps drive the sum past 24 bits.
          configure(1'b1, 16'd256, 16'hFFFF, 1'b1, 1'b0);
          count = 400;
          long_run = 1'b1;
        end
        1: begin
          configure(1'b1, 16'd511, 16'd20000, 1'b0, 1'b1);
          count = 150;
          long_run = 1'b1;
        end
        2: begin
          configure(1'b1, 16'd256, 16'd1, 1'b0, 1'b0);
          count = 80;
        end
        default: random_config();
      endcase
      for (int k = 0; k < count; k++) send_item(random_item(long_run));
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d items over %0d clip settings, %0d results checked",
             items_sent, phases_run, sb.checked);
    $display("tb_top: %0d loop wraps, %0d one-shot clamps, %0d mismatches",
             sb.wraps, sb.clamps, sb.failures);
    if (sb.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
